### design/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types, constants and saturating arithmetic for the affine-gap
// alignment cell fill unit.
// ----------------------------------------------------------------------------
package afc_pkg;

  localparam int unsigned MAX_COLS_DEF = 1024;
  localparam int unsigned SCORE_W      = 32;
  localparam int unsigned MODE_W       = 3;
  localparam int unsigned ROW_LEN_W    = 11;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 11;
  localparam int unsigned TB_W         = 8;

  localparam logic [ROW_LEN_W-1:0] ROW_LEN_RST = 11'd1024;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LEN = 1'd1;

  // alignment modes: only the zero-floor mode differs, everything else is global
  localparam logic [MODE_W-1:0] MODE_ZERO_FLOOR = 3'd1;

  // input commands
  localparam logic CMD_PRESET  = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // traceback bits
  localparam int unsigned TB_M_M = 1;
  localparam int unsigned TB_M_U = 2;
  localparam int unsigned TB_M_L = 3;
  localparam int unsigned TB_U_O = 4;
  localparam int unsigned TB_U_E = 5;
  localparam int unsigned TB_L_O = 6;
  localparam int unsigned TB_L_E = 7;

  localparam logic signed [SCORE_W-1:0] NEG_INF   = 32'sh8000_0000;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7fff_ffff;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0001;

  typedef logic signed [SCORE_W-1:0] score_t;

  typedef struct packed {
    score_t m;
    score_t u;
    score_t l;
  } cell_t;

  typedef struct packed {
    score_t row_open;
    score_t row_ext;
    score_t col_open;
    score_t col_ext;
    score_t match;
    logic   masked;
    logic   local_mode;
  } calc_ctl_t;

  // minus infinity absorbs, everything else clamps to the finite range
  function automatic score_t add_sat(input score_t a, input score_t b);
    logic signed [SCORE_W:0] s;
    score_t r;
    s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
    if (a == NEG_INF || b == NEG_INF) begin
      r = NEG_INF;
    end else if (s[SCORE_W:SCORE_W-1] == 2'b01) begin
      r = SCORE_MAX;
    end else if (s[SCORE_W:SCORE_W-1] == 2'b10 || s[SCORE_W-1:0] == NEG_INF) begin
      r = SCORE_MIN;
    end else begin
      r = s[SCORE_W-1:0];
    end
    return r;
  endfunction

endpackage

### design/afc_if.sv
// ----------------------------------------------------------------------------
// afc_in_if / afc_out_if
// Valid/ready channels carrying one cell command word and one cell result word.
// ----------------------------------------------------------------------------
interface afc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [31:0]            subst_score;
  logic signed [31:0]            row_gap_open;
  logic signed [31:0]            row_gap_extend;
  logic signed [31:0]            col_gap_open;
  logic signed [31:0]            col_gap_extend;
  logic                          masked;
  logic signed [31:0]            boundary_match;
  logic signed [31:0]            boundary_up;
  logic signed [31:0]            boundary_left;

  modport source (
    output valid, cmd, subst_score, row_gap_open, row_gap_extend, col_gap_open,
           col_gap_extend, masked, boundary_match, boundary_up, boundary_left,
    input  ready
  );
  modport sink (
    input  valid, cmd, subst_score, row_gap_open, row_gap_extend, col_gap_open,
           col_gap_extend, masked, boundary_match, boundary_up, boundary_left,
    output ready
  );
endinterface

interface afc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cell_match_score;
  logic signed [31:0] cell_up_score;
  logic signed [31:0] cell_left_score;
  logic [7:0]         traceback;
  logic               last_in_row;

  modport source (
    output valid, cell_match_score, cell_up_score, cell_left_score, traceback,
           last_in_row,
    input  ready
  );
  modport sink (
    input  valid, cell_match_score, cell_up_score, cell_left_score, traceback,
           last_in_row,
    output ready
  );
endinterface

### design/afc_row_mem.sv
// ----------------------------------------------------------------------------
// afc_row_mem
// Row buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module afc_row_mem #(
  parameter int unsigned Depth = afc_pkg::MAX_COLS_DEF + 1,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  afc_pkg::cell_t        wdata_i,
  input  logic [AddrW-1:0]      raddr_i,
  output afc_pkg::cell_t        rdata_o
);

  afc_pkg::cell_t mem [Depth];
  afc_pkg::cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/afc_cell_calc.sv
// ----------------------------------------------------------------------------
// afc_cell_calc
// Three-state cell recurrence: match, insert-up and insert-left maxima with
// traceback tie bits.
// ----------------------------------------------------------------------------
module afc_cell_calc (
  input  afc_pkg::cell_t            diag_i,
  input  afc_pkg::cell_t            up_i,
  input  afc_pkg::score_t           left_m_i,
  input  afc_pkg::score_t           left_l_i,
  input  afc_pkg::calc_ctl_t        ctl_i,
  output afc_pkg::cell_t            cell_o,
  output logic [afc_pkg::TB_W-1:0]  tb_o
);

  afc_pkg::score_t mm, mu, ml, best, uo, ue, lo, le, u, l;
  logic [afc_pkg::TB_W-1:0] tb;

  always_comb begin
    mm = afc_pkg::add_sat(diag_i.m, ctl_i.match);
    mu = afc_pkg::add_sat(diag_i.u, ctl_i.match);
    ml = afc_pkg::add_sat(diag_i.l, ctl_i.match);
    uo = afc_pkg::add_sat(up_i.m, ctl_i.row_open);
    ue = afc_pkg::add_sat(up_i.u, ctl_i.row_ext);
    lo = afc_pkg::add_sat(left_m_i, ctl_i.col_open);
    le = afc_pkg::add_sat(left_l_i, ctl_i.col_ext);

    // local mode starts the maximum at zero
    best = ctl_i.local_mode ? '0 : afc_pkg::NEG_INF;
    if (mm > best) best = mm;
    if (mu > best) best = mu;
    if (ml > best) best = ml;
    u = (ue > uo) ? ue : uo;
    l = (le > lo) ? le : lo;

    tb = '0;
    tb[afc_pkg::TB_M_M] = (mm == best);
    tb[afc_pkg::TB_M_U] = (mu == best);
    tb[afc_pkg::TB_M_L] = (ml == best);
    tb[afc_pkg::TB_U_O] = (uo == u);
    tb[afc_pkg::TB_U_E] = (ue == u);
    tb[afc_pkg::TB_L_O] = (lo == l);
    tb[afc_pkg::TB_L_E] = (le == l);

    if (ctl_i.masked) begin
      cell_o = '0;
      tb_o   = '0;
    end else begin
      cell_o.m = best;
      cell_o.u = u;
      cell_o.l = l;
      tb_o     = tb;
    end
  end

endmodule

### design/affine_gap_alignment_cell_fill_unit.sv
// ----------------------------------------------------------------------------
// affine_gap_alignment_cell_fill_unit
// Fills an affine-gap alignment matrix one cell per word in raster order,
// keeping the row above in a synchronous row buffer.
// ----------------------------------------------------------------------------
//
//  channel   direction  word
//  --------  ---------  ----------------------------------------------------
//  in_i      sink       cmd, scores, gap costs, mask, boundary scores
//  out_o     source     match/up/left scores, traceback, last_in_row
//  cfg_*     write      register index, write data (mode, row length)
//
//  one word per cycle while out_o is not stalled; a result appears in the cycle
//  after its cell word is taken, from the output register.
//  the row buffer is read one column ahead, so the up cell is waiting when the
//  word arrives; the diagonal and left cells are held in registers.
//  preset words and dropped boundary computes give no result.
//  reset clears the column counter, neighbor registers and output valid; the
//  row buffer is not cleared.
//  in_i.ready drops only while a result waits and out_o.ready is low.
//
module affine_gap_alignment_cell_fill_unit #(
  parameter int unsigned MaxCols = afc_pkg::MAX_COLS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  afc_in_if.sink                          in_i,
  afc_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [afc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [afc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned Depth = MaxCols + 1;
  localparam int unsigned ColW  = $clog2(Depth);

  // configuration
  logic [afc_pkg::MODE_W-1:0]    mode_q;
  logic [afc_pkg::ROW_LEN_W-1:0] row_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= '0;
      row_len_q <= afc_pkg::ROW_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        afc_pkg::CFG_MODE:    mode_q    <= cfg_data_i[afc_pkg::MODE_W-1:0];
        afc_pkg::CFG_ROW_LEN: row_len_q <= cfg_data_i[afc_pkg::ROW_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective row length, clamped to 1..MaxCols
  logic [31:0]     row_len_ext;
  logic [ColW-1:0] len;

  always_comb begin
    row_len_ext = 32'(row_len_q);
    if (row_len_q == '0) begin
      len = ColW'(1);
    end else if (row_len_ext > 32'(MaxCols)) begin
      len = ColW'(MaxCols);
    end else begin
      len = ColW'(row_len_ext);
    end
  end

  // position and neighbor state
  logic [ColW-1:0] col_q, col_d;
  logic            first_row_q, first_row_d;
  afc_pkg::score_t left_m_q, left_l_q;
  afc_pkg::cell_t  diag_q;
  afc_pkg::cell_t  up_cell;

  logic out_valid_q;
  logic in_ready;
  logic accept, is_compute, store, emit, last;

  assign in_ready   = !out_valid_q || out_o.ready;
  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;
  assign is_compute = (in_i.cmd == afc_pkg::CMD_COMPUTE);
  // a compute word in row 0 or column 0 is dropped without side effects
  assign emit       = accept && is_compute && !first_row_q && (col_q != '0);
  assign store      = (accept && !is_compute) || emit;
  assign last       = (col_q >= len);

  always_comb begin
    col_d       = col_q;
    first_row_d = first_row_q;
    if (store) begin
      if (last) begin
        col_d       = '0;
        first_row_d = 1'b0;
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  // cell recurrence
  afc_pkg::calc_ctl_t       ctl;
  afc_pkg::cell_t           calc_cell, new_cell;
  logic [afc_pkg::TB_W-1:0] calc_tb;

  always_comb begin
    ctl.row_open   = in_i.row_gap_open;
    ctl.row_ext    = in_i.row_gap_extend;
    ctl.col_open   = in_i.col_gap_open;
    ctl.col_ext    = in_i.col_gap_extend;
    ctl.match      = in_i.subst_score;
    ctl.masked     = in_i.masked;
    ctl.local_mode = (mode_q == afc_pkg::MODE_ZERO_FLOOR);
  end

  afc_cell_calc u_calc (
    .diag_i   (diag_q),
    .up_i     (up_cell),
    .left_m_i (left_m_q),
    .left_l_i (left_l_q),
    .ctl_i    (ctl),
    .cell_o   (calc_cell),
    .tb_o     (calc_tb)
  );

  always_comb begin
    if (is_compute) begin
      new_cell = calc_cell;
    end else begin
      new_cell.m = in_i.boundary_match;
      new_cell.u = in_i.boundary_up;
      new_cell.l = in_i.boundary_left;
    end
  end

  // row buffer: read address follows the next column, so the data register
  // always holds the entry of the current column
  afc_row_mem #(
    .Depth (Depth),
    .AddrW (ColW)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (col_q),
    .wdata_i (new_cell),
    .raddr_i (col_d),
    .rdata_o (up_cell)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      first_row_q <= 1'b1;
      left_m_q    <= '0;
      left_l_q    <= '0;
      diag_q      <= '0;
    end else begin
      col_q       <= col_d;
      first_row_q <= first_row_d;
      if (store) begin
        // old entry of this column becomes the next cell's diagonal
        diag_q   <= up_cell;
        left_m_q <= new_cell.m;
        left_l_q <= new_cell.l;
      end
    end
  end

  // output register
  afc_pkg::cell_t           out_cell_q;
  logic [afc_pkg::TB_W-1:0] out_tb_q;
  logic                     out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_cell_q <= calc_cell;
      out_tb_q   <= calc_tb;
      out_last_q <= last;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.cell_match_score = out_cell_q.m;
  assign out_o.cell_up_score    = out_cell_q.u;
  assign out_o.cell_left_score  = out_cell_q.l;
  assign out_o.traceback        = out_tb_q;
  assign out_o.last_in_row      = out_last_q;

endmodule

### design/afc_check.sv
// ----------------------------------------------------------------------------
// afc_check
// Port-level checks for the cell fill unit, bound to the top level.
// ----------------------------------------------------------------------------
module afc_check (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [31:0]        out_match,
  input logic [afc_pkg::TB_W-1:0]  out_tb
);

  // a held result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a held result keeps its match score and traceback
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_match) && $stable(out_tb))
    else $error("result changed while stalled");

  // an empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // up and left maxima each mark a source, or the cell is masked and marks none; bit 0 stays clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> ((out_tb[5:4] != 2'b00) == (out_tb[7:6] != 2'b00)) && !out_tb[0])
    else $error("inconsistent traceback");

  // no result straight out of reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind affine_gap_alignment_cell_fill_unit afc_check u_afc_check (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_match (out_o.cell_match_score),
  .out_tb    (out_o.traceback)
);

### tb/sv/affine_gap_alignment_cell_fill_unit_tb.sv
// ----------------------------------------------------------------------------
// affine_gap_alignment_cell_fill_unit_tb
// Drives cell words into the affine-gap fill unit and checks every result
// word against a cycle-free score predictor kept in step with the block:
// a short directed table first, then random matrices over several modes and
// row lengths, with random idling on both channels and a long receiver stall.
// ----------------------------------------------------------------------------
module affine_gap_alignment_cell_fill_unit_tb;

  localparam int unsigned MAX_COLS    = afc_pkg::MAX_COLS_DEF;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;

  // mode values: only the zero-floor mode differs, the rest are global variants
  localparam logic [afc_pkg::MODE_W-1:0] MODE_PLAIN      = 3'd0;
  localparam logic [afc_pkg::MODE_W-1:0] MODE_SEMI_START = 3'd2;
  localparam logic [afc_pkg::MODE_W-1:0] MODE_SEMI_END   = 3'd3;
  localparam logic [afc_pkg::MODE_W-1:0] MODE_SEMI_BOTH  = 3'd4;
  localparam logic [afc_pkg::MODE_W-1:0] MODE_RSV5       = 3'd5;
  localparam logic [afc_pkg::MODE_W-1:0] MODE_RSV6       = 3'd6;
  localparam logic [afc_pkg::MODE_W-1:0] MODE_RSV7       = 3'd7;

  typedef enum logic {STIM_WORD, STIM_CFG} stim_kind_e;

  typedef struct packed {
    logic            cmd;
    afc_pkg::score_t subst_score;
    afc_pkg::score_t row_gap_open;
    afc_pkg::score_t row_gap_extend;
    afc_pkg::score_t col_gap_open;
    afc_pkg::score_t col_gap_extend;
    logic            masked;
    afc_pkg::score_t boundary_match;
    afc_pkg::score_t boundary_up;
    afc_pkg::score_t boundary_left;
  } cell_word_t;

  typedef struct packed {
    afc_pkg::score_t m;
    afc_pkg::score_t u;
    afc_pkg::score_t l;
    logic [7:0]      tb;
    logic            last;
  } cell_res_t;

  typedef struct {
    stim_kind_e                     kind;
    logic [afc_pkg::CFG_IDX_W-1:0]  idx;
    logic [afc_pkg::CFG_DATA_W-1:0] val;
    cell_word_t                     w;
    bit                             has_exp;
    cell_res_t                      exp;
  } stim_row_t;

  typedef struct {
    logic [afc_pkg::MODE_W-1:0]    mode;
    logic [afc_pkg::ROW_LEN_W-1:0] len;
    int unsigned                   words;
    bit                            calm;
  } phase_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [afc_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [afc_pkg::CFG_DATA_W-1:0] cfg_data;

  afc_in_if  in_ch ();
  afc_out_if out_ch ();

  affine_gap_alignment_cell_fill_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // predictor state
  afc_pkg::score_t               rb_m [0:MAX_COLS];
  afc_pkg::score_t               rb_u [0:MAX_COLS];
  afc_pkg::score_t               rb_l [0:MAX_COLS];
  bit                            rb_wr [0:MAX_COLS];
  afc_pkg::score_t               lf_m, lf_l;
  afc_pkg::score_t               dg_m, dg_u, dg_l;
  bit                            dg_ok;
  int unsigned                   col;
  bit                            first_row;
  logic [afc_pkg::MODE_W-1:0]    mode_q;
  logic [afc_pkg::ROW_LEN_W-1:0] len_q;

  cell_res_t   expected_cells [$];
  int unsigned errors;
  int unsigned words_in, cells_in, presets_in, dropped_in, masked_in, cells_checked;
  int unsigned settings_done, holds_done;
  bit          calm;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic afc_pkg::score_t sat_sum(input afc_pkg::score_t a,
                                              input afc_pkg::score_t b);
    longint s;
    if (a == afc_pkg::NEG_INF || b == afc_pkg::NEG_INF) return afc_pkg::NEG_INF;
    s = longint'(a) + longint'(b);
    if (s > longint'(afc_pkg::SCORE_MAX)) return afc_pkg::SCORE_MAX;
    if (s < longint'(afc_pkg::SCORE_MIN)) return afc_pkg::SCORE_MIN;
    return afc_pkg::score_t'(s);
  endfunction

  // store a cell at column c and move the column on
  function automatic void commit_cell(input int unsigned c, input int unsigned len,
                                      input afc_pkg::score_t m, input afc_pkg::score_t u,
                                      input afc_pkg::score_t l);
    dg_m  = rb_m[c];
    dg_u  = rb_u[c];
    dg_l  = rb_l[c];
    dg_ok = rb_wr[c];
    rb_m[c]  = m;
    rb_u[c]  = u;
    rb_l[c]  = l;
    rb_wr[c] = 1'b1;
    lf_m = m;
    lf_l = l;
    if (c >= len) begin
      col       = 0;
      first_row = 1'b0;
    end else begin
      col = c + 1;
    end
  endfunction

  // returns 1 when the word yields a result word
  function automatic bit fill_cell(input cell_word_t w, output cell_res_t r);
    int unsigned len, c;
    afc_pkg::score_t m, u, l, mm, mu, ml, uo, ue, lo, le;
    logic [7:0] tbv;
    len = (len_q == 0) ? 1 : ((len_q > MAX_COLS) ? MAX_COLS : len_q);
    c   = (col > MAX_COLS) ? MAX_COLS : col;
    r      = '0;
    r.last = (c >= len);
    if (w.cmd == afc_pkg::CMD_PRESET) begin
      commit_cell(c, len, w.boundary_match, w.boundary_up, w.boundary_left);
      return 1'b0;
    end
    if (first_row || c == 0) return 1'b0;
    tbv = '0;
    m   = '0;
    u   = '0;
    l   = '0;
    if (!w.masked) begin
      mm = sat_sum(dg_m, w.subst_score);
      mu = sat_sum(dg_u, w.subst_score);
      ml = sat_sum(dg_l, w.subst_score);
      m  = (mode_q == afc_pkg::MODE_ZERO_FLOOR) ? afc_pkg::score_t'(0) : afc_pkg::NEG_INF;
      if (mm > m) m = mm;
      if (mu > m) m = mu;
      if (ml > m) m = ml;
      tbv[afc_pkg::TB_M_M] = (mm == m);
      tbv[afc_pkg::TB_M_U] = (mu == m);
      tbv[afc_pkg::TB_M_L] = (ml == m);
      uo = sat_sum(rb_m[c], w.row_gap_open);
      ue = sat_sum(rb_u[c], w.row_gap_extend);
      u  = (ue > uo) ? ue : uo;
      tbv[afc_pkg::TB_U_O] = (uo == u);
      tbv[afc_pkg::TB_U_E] = (ue == u);
      lo = sat_sum(lf_m, w.col_gap_open);
      le = sat_sum(lf_l, w.col_gap_extend);
      l  = (le > lo) ? le : lo;
      tbv[afc_pkg::TB_L_O] = (lo == l);
      tbv[afc_pkg::TB_L_E] = (le == l);
    end
    commit_cell(c, len, m, u, l);
    r.m  = m;
    r.u  = u;
    r.l  = l;
    r.tb = tbv;
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // small values make ties common, full-range and corner values reach saturation
  function automatic afc_pkg::score_t pick_score();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return afc_pkg::score_t'(int'($urandom_range(0, 16)) - 8);
    if (r < 75) return afc_pkg::score_t'(int'($urandom_range(0, 2097152)) - 1048576);
    if (r < 90) return afc_pkg::score_t'($urandom);
    case ($urandom_range(0, 3))
      0:       return afc_pkg::NEG_INF;
      1:       return afc_pkg::SCORE_MIN;
      2:       return afc_pkg::SCORE_MAX;
      default: return afc_pkg::score_t'(0);
    endcase
  endfunction

  function automatic cell_word_t random_word();
    cell_word_t w;
    int unsigned r, c;
    w.subst_score    = pick_score();
    w.row_gap_open   = pick_score();
    w.row_gap_extend = pick_score();
    w.col_gap_open   = pick_score();
    w.col_gap_extend = pick_score();
    w.boundary_match = pick_score();
    w.boundary_up    = pick_score();
    w.boundary_left  = pick_score();
    w.masked         = ($urandom_range(0, 99) < 8);
    r = $urandom_range(0, 99);
    c = (col > MAX_COLS) ? MAX_COLS : col;
    // never compute from a row entry that has not been written yet
    if (!first_row && c != 0 && rb_wr[c] && dg_ok) begin
      w.cmd = (r < 88) ? afc_pkg::CMD_COMPUTE : afc_pkg::CMD_PRESET;
    end else if (first_row || c == 0) begin
      w.cmd = (r < 15) ? afc_pkg::CMD_COMPUTE : afc_pkg::CMD_PRESET;
    end else begin
      w.cmd = afc_pkg::CMD_PRESET;
    end
    return w;
  endfunction

  function automatic stim_row_t preset_row(input afc_pkg::score_t bm,
                                           input afc_pkg::score_t bu,
                                           input afc_pkg::score_t bl);
    stim_row_t s;
    s.kind = STIM_WORD;
    s.idx  = '0;
    s.val  = '0;
    s.w    = '0;
    s.w.cmd            = afc_pkg::CMD_PRESET;
    s.w.boundary_match = bm;
    s.w.boundary_up    = bu;
    s.w.boundary_left  = bl;
    s.has_exp = 1'b0;
    s.exp     = '0;
    return s;
  endfunction

  function automatic stim_row_t compute_row(input afc_pkg::score_t ms,
                                            input afc_pkg::score_t rgo,
                                            input afc_pkg::score_t rge,
                                            input afc_pkg::score_t cgo,
                                            input afc_pkg::score_t cge,
                                            input logic msk);
    stim_row_t s;
    s.kind = STIM_WORD;
    s.idx  = '0;
    s.val  = '0;
    s.w    = '0;
    s.w.cmd            = afc_pkg::CMD_COMPUTE;
    s.w.subst_score    = ms;
    s.w.row_gap_open   = rgo;
    s.w.row_gap_extend = rge;
    s.w.col_gap_open   = cgo;
    s.w.col_gap_extend = cge;
    s.w.masked         = msk;
    s.has_exp = 1'b0;
    s.exp     = '0;
    return s;
  endfunction

  function automatic stim_row_t config_row(input logic [afc_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [afc_pkg::CFG_DATA_W-1:0] val);
    stim_row_t s;
    s.kind    = STIM_CFG;
    s.idx     = idx;
    s.val     = val;
    s.w       = '0;
    s.has_exp = 1'b0;
    s.exp     = '0;
    return s;
  endfunction

  function automatic stim_row_t with_result(input stim_row_t s, input cell_res_t e);
    stim_row_t t;
    t         = s;
    t.has_exp = 1'b1;
    t.exp     = e;
    return t;
  endfunction

  task automatic write_reg(input logic [afc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [afc_pkg::CFG_DATA_W-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    if (idx == afc_pkg::CFG_MODE) mode_q = data[afc_pkg::MODE_W-1:0];
    else len_q = data[afc_pkg::ROW_LEN_W-1:0];
    settings_done++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (expected_cells.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic offer_word(input cell_word_t w, input bit has_typed,
                            input cell_res_t typed_res);
    int unsigned gap;
    cell_res_t res;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.cmd            = w.cmd;
    in_ch.subst_score    = w.subst_score;
    in_ch.row_gap_open   = w.row_gap_open;
    in_ch.row_gap_extend = w.row_gap_extend;
    in_ch.col_gap_open   = w.col_gap_open;
    in_ch.col_gap_extend = w.col_gap_extend;
    in_ch.masked         = w.masked;
    in_ch.boundary_match = w.boundary_match;
    in_ch.boundary_up    = w.boundary_up;
    in_ch.boundary_left  = w.boundary_left;
    in_ch.valid          = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    words_in++;
    if (fill_cell(w, res)) begin
      expected_cells.push_back(has_typed ? typed_res : res);
      cells_in++;
      if (w.masked) masked_in++;
    end else if (w.cmd == afc_pkg::CMD_PRESET) begin
      presets_in++;
    end else begin
      dropped_in++;
    end
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input cell_res_t want,
                                 input cell_res_t got);
    if (errors < 10) begin
      $display("%s: exp m=%h u=%h l=%h tb=%h last=%b got m=%h u=%h l=%h tb=%h last=%b",
               what, want.m, want.u, want.l, want.tb, want.last,
               got.m, got.u, got.l, got.tb, got.last);
    end
    errors++;
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin : receiver
    int unsigned stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        holds_done++;
      end
      if (stall_left != 0 && !calm) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        stall_left   = calm ? 0 : pick_gap();
      end
    end
  end

  initial begin : result_check
    cell_res_t got, want;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.m    = out_ch.cell_match_score;
        got.u    = out_ch.cell_up_score;
        got.l    = out_ch.cell_left_score;
        got.tb   = out_ch.traceback;
        got.last = out_ch.last_in_row;
        if (expected_cells.size() == 0) begin
          report_mismatch("result word with nothing expected", '0, got);
        end else begin
          want = expected_cells.pop_front();
          cells_checked++;
          if (got.m !== want.m || got.u !== want.u || got.l !== want.l ||
              got.tb !== want.tb || got.last !== want.last) begin
            report_mismatch("cell mismatch", want, got);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: %0d cycles without a handshake, %0d results pending",
             quiet, expected_cells.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   dir_rows [$];
    phase_t      phases [$];
    cell_res_t   typed;
    logic [afc_pkg::CFG_DATA_W-1:0] mode_word;
    int unsigned p, n;

    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    in_ch.valid          = 1'b0;
    in_ch.cmd            = afc_pkg::CMD_PRESET;
    in_ch.subst_score    = '0;
    in_ch.row_gap_open   = '0;
    in_ch.row_gap_extend = '0;
    in_ch.col_gap_open   = '0;
    in_ch.col_gap_extend = '0;
    in_ch.masked         = 1'b0;
    in_ch.boundary_match = '0;
    in_ch.boundary_up    = '0;
    in_ch.boundary_left  = '0;
    errors = 0;
    calm     = 1'b0;
    hold_req = 1'b0;
    mode_q    = MODE_PLAIN;
    len_q     = afc_pkg::ROW_LEN_RST;
    col       = 0;
    first_row = 1'b1;
    lf_m  = '0;
    lf_l  = '0;
    dg_m  = '0;
    dg_u  = '0;
    dg_l  = '0;
    dg_ok = 1'b0;
    words_in = 0; cells_in = 0; presets_in = 0; dropped_in = 0;
    masked_in = 0; cells_checked = 0; settings_done = 0; holds_done = 0;

    // directed: rows 0..5 of a three-column matrix
    dir_rows.push_back(config_row(afc_pkg::CFG_MODE, afc_pkg::CFG_DATA_W'(MODE_PLAIN)));
    dir_rows.push_back(config_row(afc_pkg::CFG_ROW_LEN, 11'd2));
    dir_rows.push_back(compute_row(1, 1, 1, 1, 1, 1'b0));      // dropped, row 0
    dir_rows.push_back(preset_row(0, afc_pkg::NEG_INF, afc_pkg::NEG_INF));
    dir_rows.push_back(preset_row(0, 0, 0));
    dir_rows.push_back(preset_row(0, 0, 0));
    dir_rows.push_back(compute_row(1, 1, 1, 1, 1, 1'b0));      // dropped, column 0
    dir_rows.push_back(preset_row(afc_pkg::SCORE_MAX, afc_pkg::NEG_INF,
                                  afc_pkg::SCORE_MAX));
    typed.m    = afc_pkg::SCORE_MAX;
    typed.u    = afc_pkg::SCORE_MAX;
    typed.l    = afc_pkg::SCORE_MAX;
    typed.tb   = (8'd1 << afc_pkg::TB_M_M) | (8'd1 << afc_pkg::TB_U_O) |
                 (8'd1 << afc_pkg::TB_U_E) | (8'd1 << afc_pkg::TB_L_O) |
                 (8'd1 << afc_pkg::TB_L_E);
    typed.last = 1'b0;
    dir_rows.push_back(with_result(compute_row(afc_pkg::SCORE_MAX, afc_pkg::SCORE_MAX,
                                               afc_pkg::SCORE_MAX, afc_pkg::SCORE_MAX,
                                               afc_pkg::SCORE_MAX, 1'b0), typed));
    typed      = '0;
    typed.last = 1'b1;
    dir_rows.push_back(with_result(compute_row(-1, -1, -1, -1, -1, 1'b1), typed));
    dir_rows.push_back(preset_row(afc_pkg::NEG_INF, afc_pkg::NEG_INF, afc_pkg::NEG_INF));
    dir_rows.push_back(compute_row(afc_pkg::SCORE_MIN, afc_pkg::SCORE_MIN,
                                   afc_pkg::SCORE_MIN, afc_pkg::SCORE_MIN,
                                   afc_pkg::SCORE_MIN, 1'b0));
    dir_rows.push_back(compute_row(-5, -3, -1, -3, -1, 1'b0));
    dir_rows.push_back(config_row(afc_pkg::CFG_MODE,
                                  afc_pkg::CFG_DATA_W'(afc_pkg::MODE_ZERO_FLOOR)));
    dir_rows.push_back(preset_row(afc_pkg::NEG_INF, afc_pkg::NEG_INF, afc_pkg::NEG_INF));
    dir_rows.push_back(compute_row(-100, -2, -1, -2, -1, 1'b0)); // zero floor
    dir_rows.push_back(compute_row(3, -2, -1, -2, -1, 1'b0));
    dir_rows.push_back(config_row(afc_pkg::CFG_MODE, afc_pkg::CFG_DATA_W'(MODE_RSV7)));
    dir_rows.push_back(preset_row(0, 0, 0));
    dir_rows.push_back(compute_row(-1, -2, -1, -2, -1, 1'b0));   // no finite match source
    dir_rows.push_back(preset_row(7, -7, 7));                    // preset at the row end
    dir_rows.push_back(preset_row(0, 0, 0));
    dir_rows.push_back(compute_row(0, 0, 0, 0, 0, 1'b0));

    phases.push_back('{MODE_PLAIN,              11'd1,    120, 1'b0});
    phases.push_back('{afc_pkg::MODE_ZERO_FLOOR, 11'd5,   180, 1'b0});
    phases.push_back('{MODE_RSV6,               11'd0,    60,  1'b1});
    phases.push_back('{MODE_SEMI_END,           11'd1024, 250, 1'b0});
    phases.push_back('{MODE_SEMI_BOTH,          11'd2047, 200, 1'b0});
    phases.push_back('{afc_pkg::MODE_ZERO_FLOOR, 11'd3,   80,  1'b1});
    phases.push_back('{MODE_RSV5,               11'd8,    100, 1'b0});
    phases.push_back('{MODE_SEMI_START,         11'd1,    40,  1'b0});
    phases.push_back('{afc_pkg::MODE_ZERO_FLOOR, 11'd1,   40,  1'b0});

    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == STIM_CFG) begin
        wait_drained();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        offer_word(dir_rows[i].w, dir_rows[i].has_exp, dir_rows[i].exp);
      end
    end

    for (p = 0; p < phases.size(); p++) begin
      wait_drained();
      calm = 1'b0;
      // unused upper data bits get random values on mode writes
      mode_word = afc_pkg::CFG_DATA_W'($urandom);
      mode_word[afc_pkg::MODE_W-1:0] = phases[p].mode;
      write_reg(afc_pkg::CFG_MODE, mode_word);
      write_reg(afc_pkg::CFG_ROW_LEN, afc_pkg::CFG_DATA_W'(phases[p].len));
      calm = phases[p].calm;
      for (n = 0; n < phases[p].words; n++) begin
        if (p == 0 && n == 40) hold_req = 1'b1;
        if (p == 1 && n == 100) wait_drained();
        offer_word(random_word(), 1'b0, '0);
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (8) @(negedge clk);
    if (expected_cells.size() != 0) begin
      $display("%0d expected result words never arrived", expected_cells.size());
      errors += expected_cells.size();
    end
    $display("run: %0d words in, %0d cells checked, %0d presets, %0d dropped, %0d masked",
             words_in, cells_checked, presets_in, dropped_in, masked_in);
    $display("run: %0d register writes over %0d settings, %0d long receiver hold-offs",
             settings_done, phases.size() + 4, holds_done);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/afc_pkg.sv
design/afc_if.sv
design/afc_row_mem.sv
design/afc_cell_calc.sv
design/affine_gap_alignment_cell_fill_unit.sv
design/afc_check.sv
tb/sv/affine_gap_alignment_cell_fill_unit_tb.sv
